@@ src/c8x_pkg.sv @@
// Shared types and constants for the CHIP-8 instruction execute block.
`default_nettype none
package c8x_pkg;

   localparam int unsigned PcWidth    = 16;
   localparam int unsigned RegWidth   = 8;
   localparam int unsigned IdxWidth   = 12;
   localparam int unsigned StatWidth  = 3;
   localparam int unsigned DefReturnDepth = 16;
   localparam logic [15:0] ResetStart = 16'h0200;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ILLEGAL   = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_UNDERFLOW = 3'd3,
      ST_UNIMPL    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_EMIT
   } fsm_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request beat
      logic exec;     // decode, update state, build first result
      logic advance;  // step to next write beat
      logic emit;     // present result beat
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic more;     // another write beat follows the current one
   } sts_type;

   // double dabble style BCD split of one byte: {hundreds, tens, ones}
   function automatic logic [11:0] bcd8(input logic [7:0] v);
      logic [19:0] s;
      s = {12'd0, v};
      for (int k = 0; k < 8; k++) begin
         if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
         if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
         s = s << 1;
      end
      return s[19:8];
   endfunction

endpackage
`default_nettype wire

@@ src/c8x_ctrl.sv @@
// Controller state machine sequencing instruction execution and result beats.
`default_nettype none
module c8x_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire c8x_pkg::sts_type  sts,
   output c8x_pkg::cmd_type       cmd
);
   c8x_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= c8x_pkg::FSM_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         c8x_pkg::FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = c8x_pkg::FSM_EXEC;
            end
         end
         c8x_pkg::FSM_EXEC: begin
            cmd.exec = 1'b1;
            state_in = c8x_pkg::FSM_EMIT;
         end
         c8x_pkg::FSM_EMIT: begin
            rsp_tvalid = 1'b1;
            cmd.emit   = 1'b1;
            if (rsp_tready) begin
               if (sts.more) cmd.advance = 1'b1;
               else          state_in = c8x_pkg::FSM_IDLE;
            end
         end
         default: state_in = c8x_pkg::FSM_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("accept while result pending");
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid) else $error("no exec cycle");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("beat dropped");
endmodule
`default_nettype wire

@@ src/c8x_dp.sv @@
// Datapath: architectural registers, return stack, decode and result beat.
`default_nettype none
module c8x_dp #(
   parameter int unsigned RETURN_DEPTH = c8x_pkg::DefReturnDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire c8x_pkg::cmd_type  cmd,
   output c8x_pkg::sts_type       sts,
   input  wire logic [15:0]       opcode,
   input  wire logic [7:0]        random_byte,
   input  wire logic              csr_write,
   input  wire logic [15:0]       csr_data,
   output logic [15:0]            next_pc,
   output logic                   mem_write,
   output logic [15:0]            mem_address,
   output logic [7:0]             mem_data,
   output logic                   clear_screen,
   output logic [2:0]             status,
   output logic                   last
);
   localparam int unsigned SpW = $clog2(RETURN_DEPTH + 1);
   localparam int unsigned SiW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;

   logic [7:0]  v_ff [16];
   logic [7:0]  v_in [16];
   logic [11:0] i_ff, i_in;
   logic [15:0] pc_ff, pc_in;
   logic [SpW-1:0] sp_ff, sp_in;
   logic [15:0] stk_ff [RETURN_DEPTH];
   logic        push;
   logic [15:0] op_ff;
   logic [7:0]  rnd_ff;
   // result beat registers
   logic [15:0] npc_ff;
   logic        wr_ff;
   logic [3:0]  cnt_ff;   // current write beat index
   logic [3:0]  lastk_ff; // index of final write beat
   logic        bcd_ff;
   logic [11:0] bcdv_ff;
   logic        clr_ff;
   logic [2:0]  st_ff;

   logic [3:0] x, y, n;
   logic [7:0] nn, vx, vy;
   logic [15:0] nxt, skp;
   logic [2:0]  st;
   logic        clr, wr, isbcd;
   logic [3:0]  lastk;
   logic [8:0]  sum9;
   logic [12:0] sum13;
   logic [SiW-1:0] rd_idx;

   assign x  = op_ff[11:8];
   assign y  = op_ff[7:4];
   assign n  = op_ff[3:0];
   assign nn = op_ff[7:0];
   assign vx = v_ff[x];
   assign vy = v_ff[y];
   assign rd_idx = SiW'(sp_ff - SpW'(1));

   always_comb begin
      for (int k = 0; k < 16; k++) v_in[k] = v_ff[k];
      i_in  = i_ff;
      sp_in = sp_ff;
      push  = 1'b0;
      nxt   = pc_ff + 16'd2;
      skp   = pc_ff + 16'd4;
      st    = c8x_pkg::ST_OK;
      clr   = 1'b0;
      wr    = 1'b0;
      isbcd = 1'b0;
      lastk = 4'd0;
      sum9  = '0;
      sum13 = '0;
      unique case (op_ff[15:12])
         4'h0: begin
            if (op_ff == 16'h00E0) clr = 1'b1;
            else if (op_ff == 16'h00EE) begin
               if (sp_ff == '0) st = c8x_pkg::ST_UNDERFLOW;
               else begin
                  sp_in = sp_ff - SpW'(1);
                  nxt   = stk_ff[rd_idx];
               end
            end else st = c8x_pkg::ST_UNIMPL;
         end
         4'h1: nxt = {4'd0, op_ff[11:0]};
         4'h2: begin
            if (sp_ff >= SpW'(RETURN_DEPTH)) st = c8x_pkg::ST_OVERFLOW;
            else begin
               push  = 1'b1;
               sp_in = sp_ff + SpW'(1);
               nxt   = {4'd0, op_ff[11:0]};
            end
         end
         4'h3: if (vx == nn) nxt = skp;
         4'h4: if (vx != nn) nxt = skp;
         4'h5: begin
            if (n != 4'd0) st = c8x_pkg::ST_ILLEGAL;
            else if (vx == vy) nxt = skp;
         end
         4'h6: v_in[x] = nn;
         4'h7: v_in[x] = vx + nn;
         4'h8: begin
            unique case (n)
               4'h0: v_in[x] = vy;
               4'h1: v_in[x] = vx | vy;
               4'h2: v_in[x] = vx & vy;
               4'h3: v_in[x] = vx ^ vy;
               4'h4: begin
                  sum9 = {1'b0, vx} + {1'b0, vy};
                  v_in[x] = sum9[7:0];
                  v_in[15] = {7'd0, sum9[8]};
               end
               4'h5: begin
                  v_in[x] = vx - vy;
                  v_in[15] = {7'd0, vx >= vy};
               end
               4'h6: begin
                  v_in[x] = {1'b0, vx[7:1]};
                  v_in[15] = {7'd0, vx[0]};
               end
               4'h7: begin
                  v_in[x] = vy - vx;
                  v_in[15] = {7'd0, vy >= vx};
               end
               4'hE: begin
                  v_in[x] = {vx[6:0], 1'b0};
                  v_in[15] = {7'd0, vx[7]};
               end
               default: st = c8x_pkg::ST_ILLEGAL;
            endcase
         end
         4'h9: begin
            if (n != 4'd0) st = c8x_pkg::ST_ILLEGAL;
            else if (vx != vy) nxt = skp;
         end
         4'hA: i_in = op_ff[11:0];
         4'hB: nxt = {8'd0, v_ff[0]} + {4'd0, op_ff[11:0]};
         4'hC: v_in[x] = nn & rnd_ff;
         4'hD: st = c8x_pkg::ST_UNIMPL;
         4'hE: st = (nn == 8'h9E || nn == 8'hA1) ? c8x_pkg::ST_UNIMPL
                                                  : c8x_pkg::ST_ILLEGAL;
         default: begin
            unique case (nn)
               8'h07, 8'h0A, 8'h15, 8'h18, 8'h29, 8'h65: st = c8x_pkg::ST_UNIMPL;
               8'h1E: begin
                  sum13 = {1'b0, i_ff} + {5'd0, vx};
                  i_in = sum13[11:0];
                  v_in[15] = {7'd0, sum13[12]};
               end
               8'h33: begin
                  wr = 1'b1; isbcd = 1'b1; lastk = 4'd2;
               end
               8'h55: begin
                  wr = 1'b1; lastk = x;
               end
               default: st = c8x_pkg::ST_ILLEGAL;
            endcase
         end
      endcase
      if (st != c8x_pkg::ST_OK &&
          !(st == c8x_pkg::ST_UNIMPL && op_ff[15:12] == 4'h0)) nxt = pc_ff;
      pc_in = nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) v_ff[k] <= '0;
         i_ff     <= '0;
         sp_ff    <= '0;
         pc_ff    <= c8x_pkg::ResetStart;
         cnt_ff   <= '0;
      end else if (csr_write) begin
         pc_ff    <= csr_data;
      end else if (cmd.exec) begin
         for (int k = 0; k < 16; k++) v_ff[k] <= v_in[k];
         i_ff   <= i_in;
         sp_ff  <= sp_in;
         pc_ff  <= pc_in;
         cnt_ff <= '0;
      end else if (cmd.advance) begin
         cnt_ff <= cnt_ff + 4'd1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= opcode;
         rnd_ff <= random_byte;
      end
      if (cmd.exec) begin
         npc_ff   <= nxt;
         wr_ff    <= wr;
         lastk_ff <= lastk;
         bcd_ff   <= isbcd;
         bcdv_ff  <= c8x_pkg::bcd8(vx);
         clr_ff   <= clr;
         st_ff    <= st;
         // push the return address, the word after the call
         if (push) stk_ff[sp_ff[SiW-1:0]] <= pc_ff + 16'd2;
      end
   end

   always_comb begin
      sts.more     = wr_ff && (cnt_ff != lastk_ff);
      next_pc      = npc_ff;
      mem_write    = wr_ff;
      mem_address  = wr_ff ? ({4'd0, i_ff} + {12'd0, cnt_ff}) : 16'd0;
      if (!wr_ff) mem_data = 8'd0;
      else if (bcd_ff) begin
         unique case (cnt_ff[1:0])
            2'd0:    mem_data = {4'd0, bcdv_ff[11:8]};
            2'd1:    mem_data = {4'd0, bcdv_ff[7:4]};
            default: mem_data = {4'd0, bcdv_ff[3:0]};
         endcase
      end else mem_data = v_ff[cnt_ff];
      clear_screen = clr_ff;
      status       = st_ff;
      last         = !sts.more;
   end

   assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SpW'(RETURN_DEPTH)) else $error("stack pointer out of range");
   assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> wr_ff) else $error("advance without write beat");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && bcd_ff) |-> cnt_ff <= 4'd2) else $error("bcd overrun");
endmodule
`default_nettype wire

@@ src/chip8_instruction_execute.sv @@
// Top level of the CHIP-8 instruction execute block.
// Usage:
//  - req_ channel: one beat per fetched instruction, tdata = {random_byte, opcode}.
//  - rsp_ channel: one or more result beats per instruction; rsp_tlast marks the
//    final one. Register dump FX55 gives X+1 write beats, BCD store FX33 three,
//    every other instruction a single beat.
//  - csr_ channel: writes the start address and loads the PC at once; write only
//    while no instruction is in flight.
// Timing: request accepted in IDLE, decode and state update in EXEC, first result
// beat valid in EMIT. With a ready receiver an instruction steps through accept,
// execute and emit; each further write beat is one more beat in EMIT. The single
// controller handles one instruction at a time.
// Reset: V registers and I cleared, stack emptied, start address and PC 0x200.
// Stall: a beat holds on rsp_ until rsp_tready; req_tready stays low meanwhile.
`default_nettype none
module chip8_instruction_execute #(
   parameter int unsigned RETURN_DEPTH = c8x_pkg::DefReturnDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // opcode[15:0], random_byte[23:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // next_pc, mem_write, mem_address,
                                         // mem_data, clear_screen, status, pad
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   c8x_pkg::cmd_type cmd;
   c8x_pkg::sts_type sts;
   logic [15:0] next_pc, mem_address;
   logic [7:0]  mem_data;
   logic        mem_write, clear_screen, last;
   logic [2:0]  status;

   // config always accepted; writes must happen only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   c8x_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .cmd(cmd)
   );

   c8x_dp #(.RETURN_DEPTH(RETURN_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .opcode(req_tdata[15:0]), .random_byte(req_tdata[23:16]),
      .csr_write(csr_valid), .csr_data(csr_data),
      .next_pc(next_pc), .mem_write(mem_write), .mem_address(mem_address),
      .mem_data(mem_data), .clear_screen(clear_screen), .status(status),
      .last(last)
   );

   assign rsp_tdata = {3'd0, status, clear_screen, mem_data, mem_address,
                       mem_write, next_pc};
   assign rsp_tlast = last;
endmodule
`default_nettype wire

@@ bench/chip8_instruction_execute_tb.sv @@
// Self-checking testbench for the CHIP-8 instruction execute block.
`timescale 1ns / 100ps
module chip8_instruction_execute_tb;

   localparam int unsigned StackDepth = c8x_pkg::DefReturnDepth;

   // Opcode field helpers
   localparam logic [15:0] OpClear  = 16'h00E0;
   localparam logic [15:0] OpReturn = 16'h00EE;
   localparam logic [7:0]  FnBcd    = 8'h33;
   localparam logic [7:0]  FnDump   = 8'h55;
   localparam logic [7:0]  FnAddI   = 8'h1E;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // opcode[15:0], random_byte[23:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // next_pc, mem_write, mem_address, mem_data,
                             // clear_screen, status, pad
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   typedef struct {
      logic [15:0] next_pc;
      logic        mem_write;
      logic [15:0] mem_address;
      logic [7:0]  mem_data;
      logic        clear_screen;
      c8x_pkg::status_type status;
      logic        last;
   } result_beat_t;

   // Shadow machine state
   logic [7:0]  vreg [16];
   logic [11:0] ireg;
   logic [15:0] pc;
   logic [15:0] ret_stack [StackDepth];
   int          depth_used;

   result_beat_t pending_beats [$];
   int           error_count;
   bit           ready_busy;   // when 0 the receiver never stalls

   chip8_instruction_execute dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   function automatic void queue_beat(logic [15:0] npc, logic wr,
                                      logic [15:0] addr, logic [7:0] data,
                                      logic clr, c8x_pkg::status_type st,
                                      logic lst);
      result_beat_t b;
      b.next_pc = npc; b.mem_write = wr; b.mem_address = addr;
      b.mem_data = data; b.clear_screen = clr; b.status = st; b.last = lst;
      pending_beats.push_back(b);
   endfunction

   // Execute one instruction on the shadow state and queue its beats.
   function automatic void execute_instr(logic [15:0] op, logic [7:0] rnd);
      logic [3:0]  x, y, n;
      logic [7:0]  nn, vx, vy, flag;
      logic [11:0] nnn;
      logic [15:0] npc, skip;
      logic [8:0]  sum9;
      logic [12:0] sum13;
      c8x_pkg::status_type st;
      logic        clr;
      int          writes;
      logic [15:0] waddr [16];
      logic [7:0]  wdata [16];
      x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
      vx = vreg[x]; vy = vreg[y];
      npc = pc + 16'd2; skip = pc + 16'd4;
      st = c8x_pkg::ST_OK; clr = 1'b0; writes = 0;
      case (op[15:12])
         4'h0: begin
            if (op == OpClear) clr = 1'b1;
            else if (op == OpReturn) begin
               if (depth_used == 0) st = c8x_pkg::ST_UNDERFLOW;
               else begin
                  depth_used--;
                  npc = ret_stack[depth_used];
               end
            end else st = c8x_pkg::ST_UNIMPL;
         end
         4'h1: npc = {4'h0, nnn};
         4'h2: begin
            if (depth_used >= StackDepth) st = c8x_pkg::ST_OVERFLOW;
            else begin
               ret_stack[depth_used] = npc;
               depth_used++;
               npc = {4'h0, nnn};
            end
         end
         4'h3: if (vx == nn) npc = skip;
         4'h4: if (vx != nn) npc = skip;
         4'h5: if (n != 4'h0) st = c8x_pkg::ST_ILLEGAL; else if (vx == vy) npc = skip;
         4'h6: vreg[x] = nn;
         4'h7: vreg[x] = vx + nn;
         4'h8: begin
            case (n)
               4'h0: vreg[x] = vy;
               4'h1: vreg[x] = vx | vy;
               4'h2: vreg[x] = vx & vy;
               4'h3: vreg[x] = vx ^ vy;
               4'h4: begin
                  sum9 = {1'b0, vx} + {1'b0, vy};
                  vreg[x] = sum9[7:0];
                  vreg[15] = {7'd0, sum9[8]};
               end
               4'h5: begin
                  flag = (vx >= vy) ? 8'd1 : 8'd0;
                  vreg[x] = vx - vy;
                  vreg[15] = flag;
               end
               4'h6: begin
                  flag = {7'd0, vx[0]};
                  vreg[x] = vx >> 1;
                  vreg[15] = flag;
               end
               4'h7: begin
                  flag = (vy >= vx) ? 8'd1 : 8'd0;
                  vreg[x] = vy - vx;
                  vreg[15] = flag;
               end
               4'hE: begin
                  flag = {7'd0, vx[7]};
                  vreg[x] = vx << 1;
                  vreg[15] = flag;
               end
               default: st = c8x_pkg::ST_ILLEGAL;
            endcase
         end
         4'h9: if (n != 4'h0) st = c8x_pkg::ST_ILLEGAL; else if (vx != vy) npc = skip;
         4'hA: ireg = nnn;
         4'hB: npc = {8'h00, vreg[0]} + {4'h0, nnn};
         4'hC: vreg[x] = nn & rnd;
         4'hD: st = c8x_pkg::ST_UNIMPL;
         4'hE: st = (nn == 8'h9E || nn == 8'hA1) ? c8x_pkg::ST_UNIMPL
                                                  : c8x_pkg::ST_ILLEGAL;
         default: begin
            case (nn)
               8'h07, 8'h0A, 8'h15, 8'h18, 8'h29, 8'h65: st = c8x_pkg::ST_UNIMPL;
               FnAddI: begin
                  sum13 = {1'b0, ireg} + {5'd0, vx};
                  ireg = sum13[11:0];
                  vreg[15] = {7'd0, sum13[12]};
               end
               FnBcd: begin
                  for (int k = 0; k < 3; k++) waddr[k] = {4'h0, ireg} + 16'(k);
                  wdata[0] = 8'(vx / 100);
                  wdata[1] = 8'((vx / 10) % 10);
                  wdata[2] = 8'(vx % 10);
                  writes = 3;
               end
               FnDump: begin
                  for (int k = 0; k <= x; k++) begin
                     waddr[k] = {4'h0, ireg} + 16'(k);
                     wdata[k] = vreg[k];
                  end
                  writes = x + 1;
               end
               default: st = c8x_pkg::ST_ILLEGAL;
            endcase
         end
      endcase
      // Faults hold the PC, except unknown 0NNN which still steps past it
      if (st != c8x_pkg::ST_OK && !(st == c8x_pkg::ST_UNIMPL && op[15:12] == 4'h0))
         npc = pc;
      pc = npc;
      if (writes == 0) queue_beat(npc, 1'b0, 16'h0, 8'h0, clr, st, 1'b1);
      else
         for (int k = 0; k < writes; k++)
            queue_beat(npc, 1'b1, waddr[k], wdata[k], clr, st, k == writes - 1);
   endfunction

   // Short gaps mostly, an occasional long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drive one instruction beat and wait for it to be taken.
   task automatic send_instr(input logic [15:0] op, input logic [7:0] rnd);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rnd, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      execute_instr(op, rnd);
   endtask

   // Drain every expected beat, then let the pipeline settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_start(input logic [15:0] addr);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= addr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pc = addr;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Opcode generator biased toward well-formed instructions.
   function automatic logic [15:0] random_opcode();
      logic [15:0] op;
      logic [3:0]  fn8 [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
      logic [7:0]  fnf [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29,
                               8'h33, 8'h55, 8'h65};
      op = 16'($urandom);
      if ($urandom_range(0, 9) == 0) return op;   // raw noise
      case (op[15:12])
         4'h0: case ($urandom_range(0, 3))
                  0: op = OpClear;
                  1, 2: op = OpReturn;
                  default: ;
               endcase
         4'h5, 4'h9: if ($urandom_range(0, 4) != 0) op[3:0] = 4'h0;
         4'h8: if ($urandom_range(0, 5) != 0) op[3:0] = fn8[$urandom_range(0, 8)];
         4'hE: op[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
         4'hF: if ($urandom_range(0, 5) != 0) op[7:0] = fnf[$urandom_range(0, 8)];
         default: ;
      endcase
      return op;
   endfunction

   // Receiver side: random stalls with calm stretches.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= 1'b1;
         repeat (ready_busy ? $urandom_range(0, 6) : 30) @(negedge clock);
         if (ready_busy) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap()) @(negedge clock);
         end
      end
   end

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      result_beat_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("unexpected beat next_pc", rsp_tdata[15:0], 16'h0);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_tdata[15:0] !== want.next_pc)
               report_mismatch("next_pc", rsp_tdata[15:0], want.next_pc);
            if (rsp_tdata[16] !== want.mem_write)
               report_mismatch("mem_write", 16'(rsp_tdata[16]), 16'(want.mem_write));
            if (rsp_tdata[32:17] !== want.mem_address)
               report_mismatch("mem_address", rsp_tdata[32:17], want.mem_address);
            if (rsp_tdata[40:33] !== want.mem_data)
               report_mismatch("mem_data", 16'(rsp_tdata[40:33]), 16'(want.mem_data));
            if (rsp_tdata[41] !== want.clear_screen)
               report_mismatch("clear_screen", 16'(rsp_tdata[41]),
                               16'(want.clear_screen));
            if (rsp_tdata[44:42] !== want.status)
               report_mismatch("status", 16'(rsp_tdata[44:42]), 16'(want.status));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 16'(rsp_tlast), 16'(want.last));
         end
      end
   end

   // ALU ops, flags landing in VF, extremes of the data.
   task automatic test_alu();
      send_instr(16'h60FF, 8'h00);   // V0 = FF
      send_instr(16'h6101, 8'hFF);   // V1 = 01
      send_instr(16'h8014, 8'h00);   // carry out
      send_instr(16'h8015, 8'h00);   // borrow
      send_instr(16'h6F81, 8'h00);
      send_instr(16'h8F0E, 8'h00);   // shift left of VF, flag wins
      send_instr(16'h8F06, 8'h00);
      send_instr(16'h8107, 8'h00);
      send_instr(16'h8011, 8'h00);
      send_instr(16'h8012, 8'h00);
      send_instr(16'h8013, 8'h00);
      send_instr(16'h8010, 8'h00);
      send_instr(16'h70FF, 8'h00);
      send_instr(16'hC2FF, 8'hA5);
      send_instr(16'hC3FF, 8'h5A);
   endtask

   // Jumps, skips and return-stack faults.
   task automatic test_flow();
      send_instr(OpReturn, 8'h00);   // underflow on empty stack
      send_instr(16'h2FFE, 8'h00);
      send_instr(OpReturn, 8'h00);
      send_instr(16'h30FE, 8'h00);
      send_instr(16'h4000, 8'h00);
      send_instr(16'h5010, 8'h00);
      send_instr(16'h9010, 8'h00);
      send_instr(16'hBFFF, 8'h00);
      send_instr(16'h1FFF, 8'h00);
      for (int k = 0; k <= StackDepth; k++)   // last call overflows
         send_instr(16'h2000 | 16'(k * 16), 8'h00);
      for (int k = 0; k <= StackDepth; k++)   // last return underflows
         send_instr(OpReturn, 8'h00);
   endtask

   // Index register, BCD store and register dump.
   task automatic test_memory();
      send_instr(16'hAFFF, 8'h00);
      send_instr(16'hF01E, 8'h00);   // I wraps, VF = 1
      send_instr(16'hAFFD, 8'h00);
      send_instr(16'hF033, 8'h00);
      send_instr(16'hFF55, 8'h00);
      send_instr(16'hF055, 8'h00);
   endtask

   // Clear, illegal and unimplemented codes.
   task automatic test_faults();
      send_instr(OpClear, 8'h00);
      send_instr(16'h0123, 8'h00);
      send_instr(16'h00E1, 8'h00);
      send_instr(16'h8008, 8'h00);
      send_instr(16'h800F, 8'h00);
      send_instr(16'hD123, 8'h00);
      send_instr(16'hE19E, 8'h00);
      send_instr(16'hE2A1, 8'h00);
      send_instr(16'hE300, 8'h00);
      send_instr(16'hF465, 8'h00);
      send_instr(16'hF4FF, 8'h00);
   endtask

   task automatic test_random(input int count);
      for (int k = 0; k < count; k++) begin
         if (k % 15 == 5) ready_busy = 1'b0;
         if (k % 15 == 10) ready_busy = 1'b1;
         send_instr(random_opcode(), 8'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      error_count = 0;
      ready_busy = 1'b1;
      foreach (vreg[k]) vreg[k] = '0;
      foreach (ret_stack[k]) ret_stack[k] = '0;
      ireg = '0;
      depth_used = 0;
      pc = c8x_pkg::ResetStart;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_alu();
      test_flow();
      test_memory();
      test_faults();
      write_start(16'hFFFF);   // PC wraps past the top
      send_instr(16'h6000, 8'h00);
      test_random(15);
      write_start(16'h0000);
      test_random(15);
      write_start(16'($urandom));
      test_random(15);
      write_start(c8x_pkg::ResetStart);
      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_beats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
src/c8x_pkg.sv
src/c8x_ctrl.sv
src/c8x_dp.sv
src/chip8_instruction_execute.sv
bench/chip8_instruction_execute_tb.sv
